// File: sv/grid_ray_march_core_macros.svh
// Assertion macros shared by the ray march core.
`ifndef GRID_RAY_MARCH_CORE_MACROS_SVH
`define GRID_RAY_MARCH_CORE_MACROS_SVH

`ifndef SYNTHESIS

`define GRM_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("grid_ray_march_core check failed");

`define GRM_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) \
    else $error("grid_ray_march_core check failed");

`else

`define GRM_ASSERT(name, clk, rst, prop)

`define GRM_ASSERT_ALWAYS(name, clk, prop)

`endif

`endif

// File: sv/grm_pkg.sv
// Constants, types and sine table builder for the ray march core.
`timescale 1ns / 1ps
`default_nettype none

package grm_pkg;

  localparam int GRID_WIDTH       = 32;
  localparam int GRID_HEIGHT      = 32;
  localparam int CELL_LOG2        = 6;
  localparam int CELL_PIXELS      = 1 << CELL_LOG2;
  localparam int ANGLE_STEPS_LOG2 = 12;

  localparam int CELL_COUNT = GRID_WIDTH * GRID_HEIGHT;
  localparam int CELL_AW    = $clog2(CELL_COUNT);

  // Field widths of the stream beats
  localparam int ANGLE_FW = 12;
  localparam int POS_FW   = 20;
  localparam int INDEX_FW = 10;
  localparam int S_DATA_W = 64;
  localparam int M_DATA_W = 40;

  localparam int ANG_W   = ANGLE_STEPS_LOG2;
  localparam int QUARTER = 1 << (ANGLE_STEPS_LOG2 - 2);
  localparam int QTR_AW  = ANGLE_STEPS_LOG2 - 1;

  localparam int FRAC_BITS = 14;
  localparam int SINE_W    = FRAC_BITS + 1;
  localparam int DIR_W     = FRAC_BITS + 2;

  // Internal position: Q14 pixels, wide enough for the origin range and the map
  localparam int MAP_PIX_LOG2 =
    $clog2((GRID_WIDTH > GRID_HEIGHT ? GRID_WIDTH : GRID_HEIGHT) * CELL_PIXELS);
  localparam int PIX_INT_W = (MAP_PIX_LOG2 > POS_FW - 8) ? MAP_PIX_LOG2 : POS_FW - 8;
  localparam int POS_W     = PIX_INT_W + FRAC_BITS + 3;
  localparam int SPAN_LOG2 = CELL_LOG2 + FRAC_BITS;
  localparam int CX_W      = POS_W - SPAN_LOG2;
  localparam int OUT_SHIFT = FRAC_BITS - 8;

  localparam logic signed [POS_W-1:0] POS_MAX = POS_W'(524287);
  localparam logic signed [POS_W-1:0] POS_MIN = -POS_W'(524288);

  localparam logic OP_CAST  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam longint unsigned TWO_PI_Q30 = 64'd6746518853;

  // Q64 reciprocals of the series steps (n+1)(n+2) for n = 1, 3, ..., 13;
  // exact floor division for dividends well below 2^56
  localparam logic [127:0] FACT_RECIP [7] = '{
    (128'd1 << 64) / 6 + 1,
    (128'd1 << 64) / 20 + 1,
    (128'd1 << 64) / 42 + 1,
    (128'd1 << 64) / 72 + 1,
    (128'd1 << 64) / 110 + 1,
    (128'd1 << 64) / 156 + 1,
    (128'd1 << 64) / 210 + 1
  };

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_COS   = 7'b0000100,
    ST_SIN   = 7'b0001000,
    ST_LOAD  = 7'b0010000,
    ST_MARCH = 7'b0100000,
    ST_DONE  = 7'b1000000
  } state_t;

  typedef logic [SINE_W-1:0] sine_rom_t [QUARTER+1];

  // Quarter-wave sine in Q1.14 by a truncating Taylor series in Q30
  function automatic sine_rom_t build_sine_rom();
    sine_rom_t rom;
    longint unsigned theta;
    longint unsigned t2;
    longint unsigned term;
    logic [127:0] wide;
    longint sum;
    bit neg;
    int k;
    int j;
    for (k = 0; k <= QUARTER; k++) begin
      theta = (longint'(k) * TWO_PI_Q30 + (64'd1 << (ANGLE_STEPS_LOG2 - 1)))
              >> ANGLE_STEPS_LOG2;
      t2    = (theta * theta) >> 30;
      term  = theta;
      sum   = longint'(theta);
      neg   = 1'b1;
      for (j = 0; j < 7; j++) begin
        wide = 128'((term * t2) >> 30) * FACT_RECIP[j];
        term = wide[127:64];
        if (neg) sum = sum - longint'(term);
        else sum = sum + longint'(term);
        neg = !neg;
      end
      sum = (sum + 32768) / 65536;
      if (sum < 0) sum = 0;
      if (sum > 16384) sum = 16384;
      rom[k] = sum[SINE_W-1:0];
    end
    return rom;
  endfunction

endpackage

`default_nettype wire

// File: sv/grid_ray_march_core.sv
// Fixed-step ray marcher over a one-bit grid wall map.
//
// A write beat (tuser = 1) stores one wall bit. A cast beat (tuser = 0) runs
// the sine/cosine table lookup through ST_COS, ST_SIN and ST_LOAD, then takes
// one one-pixel step per cycle, then a wall test when the ray stops in a wall,
// and a load of the result in ST_DONE; the single read port of the wall map
// sets the pace of one step per cycle. The ray is never tested at
// its start; it stops after the first step that lands in a wall cell or leaves
// the map. The result waits in an output register, so the next beat is taken
// while it is pending. After reset the map is cleared to open by a pass over all
// 1024 cells, one cell per cycle, with s_tready held low.
`timescale 1ns / 1ps
`default_nettype none

`include "grid_ray_march_core_macros.svh"

module grid_ray_march_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          s_tvalid,
  output logic                               s_tready,
  // angle[11:0], origin_x[31:12], origin_y[51:32], cell_index[61:52],
  // cell_wall[62], zero[63]
  input  wire logic [grm_pkg::S_DATA_W-1:0]  s_tdata,
  // op[0]
  input  wire logic                          s_tuser,
  output logic                               m_tvalid,
  input  wire logic                          m_tready,
  // end_x[19:0], end_y[39:20]
  output logic      [grm_pkg::M_DATA_W-1:0]  m_tdata,
  // hit_wall[0]
  output logic                               m_tuser
);

  import grm_pkg::*;

  localparam sine_rom_t SINE_ROM = build_sine_rom();

  // Input beat fields
  logic        [ANGLE_FW-1:0] s_angle;
  logic signed [POS_FW-1:0]   s_origin_x;
  logic signed [POS_FW-1:0]   s_origin_y;
  logic        [INDEX_FW-1:0] s_cell_index;
  logic                       s_cell_wall;

  assign s_angle      = s_tdata[ANGLE_FW-1:0];
  assign s_origin_x   = s_tdata[ANGLE_FW +: POS_FW];
  assign s_origin_y   = s_tdata[ANGLE_FW+POS_FW +: POS_FW];
  assign s_cell_index = s_tdata[ANGLE_FW+2*POS_FW +: INDEX_FW];
  assign s_cell_wall  = s_tdata[ANGLE_FW+2*POS_FW+INDEX_FW];

  state_t state;
  logic [CELL_AW-1:0] clr_idx;
  logic               pending;
  logic               hit;

  logic        [ANG_W-1:0] ang;
  logic signed [DIR_W-1:0] dx;
  logic signed [DIR_W-1:0] dy;
  logic signed [POS_W-1:0] px;
  logic signed [POS_W-1:0] py;

  logic [POS_FW-1:0] end_x;
  logic [POS_FW-1:0] end_y;
  logic              end_hit;

  logic s_fire;
  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // Sine table lookup: fold the angle onto the quarter wave
  logic [ANG_W-1:0]  rom_idx;
  logic [QTR_AW-1:0] rom_addr;
  logic              rom_neg;
  logic [SINE_W-1:0] rom_q;
  logic              rom_neg_q;

  always_comb begin
    rom_idx = (state == ST_COS) ? ang + ANG_W'(QUARTER) : ang;
    if (rom_idx[ANG_W-2]) rom_addr = QTR_AW'(QUARTER) - QTR_AW'(rom_idx[ANG_W-3:0]);
    else rom_addr = QTR_AW'(rom_idx[ANG_W-3:0]);
    rom_neg = rom_idx[ANG_W-1];
  end

  always_ff @(posedge clk) begin
    rom_q     <= SINE_ROM[rom_addr];
    rom_neg_q <= rom_neg;
  end

  logic signed [DIR_W-1:0] rom_dir;
  assign rom_dir = rom_neg_q ? -$signed(DIR_W'(rom_q)) : $signed(DIR_W'(rom_q));

  // Next step and its cell
  logic signed [POS_W-1:0] nx;
  logic signed [POS_W-1:0] ny;
  logic signed [CX_W-1:0]  cx;
  logic signed [CX_W-1:0]  cy;
  logic                    outside;
  logic [CELL_AW-1:0]      cell_addr;

  always_comb begin
    nx        = px + POS_W'(dx);
    ny        = py + POS_W'(dy);
    cx        = CX_W'(nx >>> SPAN_LOG2);
    cy        = CX_W'(ny >>> SPAN_LOG2);
    outside   = (cx < 0) || (cx >= CX_W'(GRID_WIDTH)) ||
                (cy < 0) || (cy >= CX_W'(GRID_HEIGHT));
    cell_addr = CELL_AW'(cy * GRID_WIDTH + cx);
  end

  // Wall map: one write port, one registered read port
  logic               wall_map [CELL_COUNT];
  logic               map_we;
  logic [CELL_AW-1:0] map_waddr;
  logic               map_wdata;
  logic               map_rd;

  always_comb begin
    map_we    = 1'b0;
    map_waddr = clr_idx;
    map_wdata = 1'b0;
    if (state == ST_CLEAR) begin
      map_we = 1'b1;
    end else if (s_fire && s_tuser == OP_WRITE && s_cell_index < CELL_COUNT) begin
      map_we    = 1'b1;
      map_waddr = CELL_AW'(s_cell_index);
      map_wdata = s_cell_wall;
    end
  end

  always_ff @(posedge clk) begin
    if (map_we) wall_map[map_waddr] <= map_wdata;
    map_rd <= wall_map[cell_addr];
  end

  function automatic logic [POS_FW-1:0] sat_pos(logic signed [POS_W-1:0] q14);
    logic signed [POS_W-1:0] v;
    v = q14 >>> OUT_SHIFT;
    if (v > POS_MAX) v = POS_MAX;
    if (v < POS_MIN) v = POS_MIN;
    return v[POS_FW-1:0];
  endfunction

  logic out_free;
  logic out_load;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_DONE) && out_free;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      pending  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) m_tvalid <= 1'b1;
      else if (m_tvalid && m_tready) m_tvalid <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == CELL_AW'(CELL_COUNT - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (s_fire && s_tuser == OP_CAST) state <= ST_COS;
        end
        ST_COS:  state <= ST_SIN;
        ST_SIN:  state <= ST_LOAD;
        ST_LOAD: begin
          pending <= 1'b0;
          state   <= ST_MARCH;
        end
        ST_MARCH: begin
          if (pending && map_rd) begin
            pending <= 1'b0;
            state   <= ST_DONE;
          end else if (outside) begin
            pending <= 1'b0;
            state   <= ST_DONE;
          end else begin
            pending <= 1'b1;
          end
        end
        ST_DONE: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_CLEAR;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_fire) begin
          ang <= ANG_W'(s_angle);
          px  <= POS_W'(s_origin_x) <<< OUT_SHIFT;
          py  <= POS_W'(s_origin_y) <<< OUT_SHIFT;
        end
      end
      ST_SIN:  dx <= rom_dir;
      ST_LOAD: dy <= rom_dir;
      ST_MARCH: begin
        if (pending && map_rd) begin
          hit <= 1'b1;
        end else begin
          px  <= nx;
          py  <= ny;
          hit <= 1'b0;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          end_x   <= sat_pos(px);
          end_y   <= sat_pos(py);
          end_hit <= hit;
        end
      end
      default: ;
    endcase
  end

  assign m_tdata = {end_y, end_x};
  assign m_tuser = end_hit;

  `GRM_ASSERT(a_clear_blocks_input, clk, rst, (state == ST_CLEAR) |-> !s_tready)
  `GRM_ASSERT(a_pending_only_marching, clk, rst, pending |-> (state == ST_MARCH))
  `GRM_ASSERT(a_cast_starts_lookup, clk, rst,
    (s_fire && s_tuser == OP_CAST) |=> (state == ST_COS))
  `GRM_ASSERT(a_done_loads_result, clk, rst,
    (state == ST_DONE && out_free) |=> (m_tvalid && state == ST_IDLE))

endmodule

`default_nettype wire
